### rtl/core/pcm_frame_deframer_checker_macros.svh
// Assertion macros for the audio frame deframer and checker.
// Used by pcm_frame_deframer_checker.sv; no other dependencies.
`ifndef PCM_FRAME_DEFRAMER_CHECKER_MACROS_SVH
`define PCM_FRAME_DEFRAMER_CHECKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PFD_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pfd assertion failed");

// next-cycle implication
`define PFD_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pfd assertion failed");

`else

`define PFD_ASSERT_NOW(name, clk, rst, pre, post)
`define PFD_ASSERT_NEXT(name, clk, rst, pre, post)

`endif

`endif

### rtl/core/pfd_pkg.sv
// Types and constants for the audio frame deframer and checker.
// No dependencies; imported by pcm_frame_deframer_checker.
package pfd_pkg;

   localparam int unsigned HDR_LEN    = 32;
   localparam int unsigned HDR_AW     = $clog2(HDR_LEN);
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 8;
   // payload, kind, stream id, sequence, offset, status, then zero fill
   localparam int unsigned RSP_FIELD_W = 8 + 8 + 32 + 32 + 32 + 4;
   localparam int unsigned RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int unsigned RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [15:0]        HDR_SIZE_VALUE = 16'(HDR_LEN);

   localparam logic [7:0] MAGIC_0 = 8'h45;   // E
   localparam logic [7:0] MAGIC_1 = 8'h56;   // V
   localparam logic [7:0] MAGIC_2 = 8'h54;   // T
   localparam logic [7:0] MAGIC_3 = 8'h31;   // 1

   localparam logic REC_PAYLOAD = 1'b0;
   localparam logic REC_SUMMARY = 1'b1;

   typedef enum logic [3:0] {
      ST_OK      = 4'd0,
      ST_SHORT   = 4'd1,
      ST_MAGIC   = 4'd2,
      ST_VERSION = 4'd3,
      ST_HDRSIZE = 4'd4,
      ST_LENGTH  = 4'd5,
      ST_KIND    = 4'd6,
      ST_FORMAT  = 4'd7,
      ST_SIZE    = 4'd8
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROTOCOL_VERSION = 3'd0,
      CSR_EXPECTED_KIND    = 3'd1,
      CSR_SAMPLE_RATE      = 3'd2,
      CSR_CHANNELS         = 3'd3,
      CSR_BITS             = 3'd4,
      CSR_CODEC            = 3'd5,
      CSR_PAYLOAD_BYTES    = 3'd6
   } csr_index_type;

endpackage

### rtl/core/pcm_frame_deframer_checker.sv
// Audio frame deframer and checker: header capture, payload pass-through, summary.
// Depends on pfd_pkg and pcm_frame_deframer_checker_macros.svh.

// A frame enters one byte per request, its final byte marked by req_tlast. The
// first 32 bytes are held as the header; every later byte leaves as a payload
// record (rsp_tuser low) via the work stage and the response register, before the
// frame is checked. On the final byte a summary record (rsp_tuser high, rsp_tlast
// high) follows with the header fields and the first failed check. One byte is
// taken every cycle unless rsp_tready stalls; a final byte with payload gives two
// records via the single response register; the next byte waits for both. The byte
// counter saturates at all ones. Write the csr port only while no frame is open.
`include "pcm_frame_deframer_checker_macros.svh"

module pcm_frame_deframer_checker
   import pfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // data_byte
   input  logic                  req_tlast,   // frame_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // payload_byte, frame_kind, stream_id, sequence_number, sample_offset, status, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // record_type
   output logic                  rsp_tlast,   // last_record
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [7:0]  protocol_version_ff;
   logic [7:0]  expected_kind_ff;
   logic [31:0] expected_sample_rate_ff;
   logic [7:0]  expected_channels_ff;
   logic [7:0]  expected_bits_ff;
   logic [7:0]  expected_codec_ff;
   logic [31:0] expected_payload_bytes_ff;

   // frame state
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]         hdr_ff [HDR_LEN];

   // work stage
   logic               s1_pay_ff, s1_pay_in;
   logic               s1_sum_ff, s1_sum_in;
   logic [7:0]         s1_byte_ff;
   logic               s1_short_ff;
   logic [COUNT_W-1:0] s1_plen_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic               req_acc;
   logic               rsp_load;
   logic               s1_free;
   logic               in_header;
   logic [COUNT_W-1:0] total;
   status_type         status;
   logic [7:0]         sum_kind;
   logic [31:0]        sum_stream, sum_seq, sum_offset;
   logic               step_acc;
   logic               short_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_version_ff       <= 8'd1;
         expected_kind_ff          <= 8'd0;
         expected_sample_rate_ff   <= 32'd16000;
         expected_channels_ff      <= 8'd1;
         expected_bits_ff          <= 8'd16;
         expected_codec_ff         <= 8'd0;
         expected_payload_bytes_ff <= 32'd640;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PROTOCOL_VERSION: protocol_version_ff       <= csr_wdata[7:0];
            CSR_EXPECTED_KIND:    expected_kind_ff          <= csr_wdata[7:0];
            CSR_SAMPLE_RATE:      expected_sample_rate_ff   <= csr_wdata;
            CSR_CHANNELS:         expected_channels_ff      <= csr_wdata[7:0];
            CSR_BITS:             expected_bits_ff          <= csr_wdata[7:0];
            CSR_CODEC:            expected_codec_ff         <= csr_wdata[7:0];
            CSR_PAYLOAD_BYTES:    expected_payload_bytes_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_load  = !rsp_valid_ff || rsp_tready;
   assign s1_free   = !(s1_pay_ff || s1_sum_ff) ||
                      (rsp_load && (s1_pay_ff ^ s1_sum_ff));
   assign req_tready = s1_free;
   assign req_acc   = req_tvalid && req_tready;
   assign in_header = !(|byte_count_ff[COUNT_W-1:HDR_AW]);
   assign total     = (byte_count_ff == COUNT_MAX) ? COUNT_MAX : byte_count_ff + 1'b1;

   always_comb begin
      byte_count_in = byte_count_ff;
      if (req_acc) begin
         byte_count_in = req_tlast ? '0 : total;
      end
   end

   // header store, written in place while the frame index is below the header length
   always_ff @(posedge clock) begin
      if (req_acc && in_header) begin
         hdr_ff[byte_count_ff[HDR_AW-1:0]] <= req_tdata;
      end
   end

   // frame checks read the store as the request of this frame left it
   always_comb begin
      if (s1_short_ff) begin
         status = ST_SHORT;
      end else if (hdr_ff[0] != MAGIC_0 || hdr_ff[1] != MAGIC_1 ||
                   hdr_ff[2] != MAGIC_2 || hdr_ff[3] != MAGIC_3) begin
         status = ST_MAGIC;
      end else if (hdr_ff[4] != protocol_version_ff) begin
         status = ST_VERSION;
      end else if ({hdr_ff[7], hdr_ff[6]} != HDR_SIZE_VALUE) begin
         status = ST_HDRSIZE;
      end else if ({hdr_ff[27], hdr_ff[26], hdr_ff[25], hdr_ff[24]} != s1_plen_ff) begin
         status = ST_LENGTH;
      end else if (hdr_ff[5] != expected_kind_ff) begin
         status = ST_KIND;
      end else if ({hdr_ff[19], hdr_ff[18], hdr_ff[17], hdr_ff[16]} !=
                      expected_sample_rate_ff ||
                   hdr_ff[20] != expected_channels_ff ||
                   hdr_ff[21] != expected_bits_ff ||
                   hdr_ff[22] != expected_codec_ff ||
                   hdr_ff[23] != 8'd0) begin
         status = ST_FORMAT;
      end else if (s1_plen_ff != expected_payload_bytes_ff) begin
         status = ST_SIZE;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      if (s1_short_ff) begin
         sum_kind   = '0;
         sum_stream = '0;
         sum_seq    = '0;
         sum_offset = '0;
      end else begin
         sum_kind   = hdr_ff[5];
         sum_stream = {hdr_ff[11], hdr_ff[10], hdr_ff[9], hdr_ff[8]};
         sum_seq    = {hdr_ff[15], hdr_ff[14], hdr_ff[13], hdr_ff[12]};
         sum_offset = {hdr_ff[31], hdr_ff[30], hdr_ff[29], hdr_ff[28]};
      end
   end

   // payload record goes first, summary after it
   always_comb begin
      s1_pay_in    = s1_pay_ff;
      s1_sum_in    = s1_sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_load && s1_pay_ff) begin
         s1_pay_in    = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DATA_W - 8){1'b0}}, s1_byte_ff};
         rsp_user_in  = REC_PAYLOAD;
         rsp_last_in  = 1'b0;
      end else if (rsp_load && s1_sum_ff) begin
         s1_sum_in    = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{RSP_PAD_W{1'b0}}, status, sum_offset, sum_seq, sum_stream,
                         sum_kind, 8'd0};
         rsp_user_in  = REC_SUMMARY;
         rsp_last_in  = 1'b1;
      end
      if (req_acc) begin
         s1_pay_in = !in_header;
         s1_sum_in = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         s1_pay_ff     <= 1'b0;
         s1_sum_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_count_ff <= byte_count_in;
         s1_pay_ff     <= s1_pay_in;
         s1_sum_ff     <= s1_sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_byte_ff  <= req_tdata;
         s1_short_ff <= !(|total[COUNT_W-1:HDR_AW]);
         s1_plen_ff  <= total - COUNT_W'(HDR_LEN);
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign step_acc  = req_acc && !req_tlast;
   assign short_out = rsp_tvalid && rsp_tuser == REC_SUMMARY && rsp_tdata[115:112] == ST_SHORT;

   `PFD_ASSERT_NEXT(a_count_clears_on_end, clock, reset, req_acc && req_tlast, byte_count_ff == '0)
   `PFD_ASSERT_NEXT(a_count_steps, clock, reset, step_acc, byte_count_ff == $past(total))
   `PFD_ASSERT_NOW(a_short_has_no_header, clock, reset, short_out, rsp_tdata[111:8] == '0)

endmodule

### verif/pfd_record_checker.sv
`timescale 1ns / 1ps
// Record checker for the audio frame deframer: follows the request and record
// streams and the csr port, predicts every record and compares it field by field.
// Depends on pfd_pkg only.
module pfd_record_checker
   import pfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // data_byte
   input  logic                  req_tlast,   // frame_end
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // payload_byte, frame_kind, stream_id, sequence_number, sample_offset, status, zero fill
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,   // record_type
   input  logic                  rsp_tlast,   // last_record
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    records_due,
   output int                    fail_count
);

   typedef struct {
      logic        rec_type;
      logic [7:0]  payload;
      logic [7:0]  kind;
      logic [31:0] stream_id;
      logic [31:0] seq_num;
      logic [31:0] offset;
      logic [3:0]  status;
      logic        is_last;
   } rec_entry_type;

   rec_entry_type      awaited_records[$];
   logic [7:0]         header_bytes [HDR_LEN];
   logic [COUNT_W-1:0] frame_len;
   logic [7:0]         reg_version, reg_kind, reg_channels, reg_bits, reg_codec;
   logic [31:0]        reg_rate, reg_payload;
   int                 errors = 0;

   function automatic logic [31:0] header_word(input int pos);
      return {header_bytes[pos + 3], header_bytes[pos + 2],
              header_bytes[pos + 1], header_bytes[pos]};
   endfunction

   // first failed check of the frame just closed
   function automatic status_type frame_verdict(input logic [COUNT_W-1:0] total);
      if (total < HDR_LEN) return ST_SHORT;
      if (header_bytes[0] != MAGIC_0 || header_bytes[1] != MAGIC_1 ||
          header_bytes[2] != MAGIC_2 || header_bytes[3] != MAGIC_3) return ST_MAGIC;
      if (header_bytes[4] != reg_version) return ST_VERSION;
      if ({header_bytes[7], header_bytes[6]} != HDR_SIZE_VALUE) return ST_HDRSIZE;
      // length compare done one bit wider so the declared field cannot wrap
      if ({1'b0, total} != 33'(HDR_LEN) + {1'b0, header_word(24)}) return ST_LENGTH;
      if (header_bytes[5] != reg_kind) return ST_KIND;
      if (header_word(16) != reg_rate || header_bytes[20] != reg_channels ||
          header_bytes[21] != reg_bits || header_bytes[22] != reg_codec ||
          header_bytes[23] != 8'd0) return ST_FORMAT;
      if (total - HDR_LEN != reg_payload) return ST_SIZE;
      return ST_OK;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("time %0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rec_entry_type      rec;
      rec_entry_type      got;
      logic [COUNT_W-1:0] total;
      if (reset) begin
         awaited_records.delete();
         frame_len    = '0;
         reg_version  = 8'd1;
         reg_kind     = 8'd0;
         reg_rate     = 32'd16000;
         reg_channels = 8'd1;
         reg_bits     = 8'd16;
         reg_codec    = 8'd0;
         reg_payload  = 32'd640;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.rec_type  = rsp_tuser;
            got.payload   = rsp_tdata[7:0];
            got.kind      = rsp_tdata[15:8];
            got.stream_id = rsp_tdata[47:16];
            got.seq_num   = rsp_tdata[79:48];
            got.offset    = rsp_tdata[111:80];
            got.status    = rsp_tdata[115:112];
            got.is_last   = rsp_tlast;
            if (awaited_records.size() == 0) begin
               $display("time %0t: unexpected record, expected none, actual type %0h data %0h",
                        $time, got.rec_type, rsp_tdata);
               errors++;
            end else begin
               rec = awaited_records.pop_front();
               check_field("record_type", 32'(rec.rec_type), 32'(got.rec_type));
               check_field("payload_byte", 32'(rec.payload), 32'(got.payload));
               check_field("frame_kind", 32'(rec.kind), 32'(got.kind));
               check_field("stream_id", rec.stream_id, got.stream_id);
               check_field("sequence_number", rec.seq_num, got.seq_num);
               check_field("sample_offset", rec.offset, got.offset);
               check_field("status", 32'(rec.status), 32'(got.status));
               check_field("last_record", 32'(rec.is_last), 32'(got.is_last));
            end
         end
         if (req_tvalid && req_tready) begin
            total = (frame_len == COUNT_MAX) ? COUNT_MAX : frame_len + 1'b1;
            if (frame_len < HDR_LEN) begin
               header_bytes[frame_len[HDR_AW-1:0]] = req_tdata;
            end else begin
               rec          = '{default: '0};
               rec.rec_type = REC_PAYLOAD;
               rec.payload  = req_tdata;
               awaited_records.insert(awaited_records.size(), rec);
            end
            frame_len = total;
            if (req_tlast) begin
               rec          = '{default: '0};
               rec.rec_type = REC_SUMMARY;
               rec.status   = frame_verdict(total);
               // a short frame never reads the header
               if (rec.status != ST_SHORT) begin
                  rec.kind      = header_bytes[5];
                  rec.stream_id = header_word(8);
                  rec.seq_num   = header_word(12);
                  rec.offset    = header_word(28);
               end
               rec.is_last = 1'b1;
               awaited_records.insert(awaited_records.size(), rec);
               frame_len = '0;
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PROTOCOL_VERSION: reg_version  = csr_wdata[7:0];
               CSR_EXPECTED_KIND:    reg_kind     = csr_wdata[7:0];
               CSR_SAMPLE_RATE:      reg_rate     = csr_wdata;
               CSR_CHANNELS:         reg_channels = csr_wdata[7:0];
               CSR_BITS:             reg_bits     = csr_wdata[7:0];
               CSR_CODEC:            reg_codec    = csr_wdata[7:0];
               CSR_PAYLOAD_BYTES:    reg_payload  = csr_wdata;
               default: ;
            endcase
         end
      end
      records_due <= awaited_records.size();
      fail_count  <= errors;
   end

endmodule

### verif/pcm_frame_deframer_checker_test.sv
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, frame stimulus, csr phases and the verdict.
// Depends on pfd_pkg, pcm_frame_deframer_checker and pfd_record_checker.
module pcm_frame_deframer_checker_test;
   import pfd_pkg::*;

   localparam int CLK_HALF         = 6;
   localparam int RESET_CYCLES     = 9;
   localparam int IDLE_LIMIT       = 2000;
   localparam int DRAIN_PAUSE      = 4;
   localparam int SETTLE_CYCLES    = 20;
   localparam int RANDOM_BYTE_GOAL = 450;
   localparam int MAX_RANDOM_PAY   = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int records_due;
   int fail_count;
   int sent_bytes  = 0;
   int idle_cycles = 0;
   int stall_left  = 0;
   int calm_left   = 0;

   // register values the frames are built against
   logic [7:0]  cfg_version  = 8'd1;
   logic [7:0]  cfg_kind     = 8'd0;
   logic [31:0] cfg_rate     = 32'd16000;
   logic [7:0]  cfg_channels = 8'd1;
   logic [7:0]  cfg_bits     = 8'd16;
   logic [7:0]  cfg_codec    = 8'd0;
   logic [31:0] cfg_payload  = 32'd640;

   logic [7:0]  frame_bytes[$];
   status_type  fault_menu[8] = '{ST_SHORT, ST_MAGIC, ST_VERSION, ST_HDRSIZE,
                                  ST_LENGTH, ST_KIND, ST_FORMAT, ST_SIZE};

   pcm_frame_deframer_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pfd_record_checker record_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .records_due (records_due),
      .fail_count  (fail_count)
   );

   always #(CLK_HALF) clock = ~clock;

   // record back-pressure: mostly short stalls, a few long ones, now and then a calm stretch
   always @(posedge clock) begin
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         roll = $urandom_range(0, 199);
         if (roll < 30) stall_left = $urandom_range(1, 3);
         else if (roll < 34) stall_left = $urandom_range(10, 40);
         else if (roll < 35) calm_left = $urandom_range(50, 200);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // lowers the request and waits for every awaited record; reads the registered count late on purpose
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (records_due != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_registers(input logic [7:0] version, input logic [7:0] kind,
                                 input logic [31:0] rate, input logic [7:0] channels,
                                 input logic [7:0] bits_per, input logic [7:0] codec,
                                 input logic [31:0] payload);
      wait_drained();
      repeat (DRAIN_PAUSE) @(posedge clock);
      cfg_version  = version;
      cfg_kind     = kind;
      cfg_rate     = rate;
      cfg_channels = channels;
      cfg_bits     = bits_per;
      cfg_codec    = codec;
      cfg_payload  = payload;
      write_reg(CSR_PROTOCOL_VERSION, 32'(version));
      write_reg(CSR_EXPECTED_KIND, 32'(kind));
      write_reg(CSR_SAMPLE_RATE, rate);
      write_reg(CSR_CHANNELS, 32'(channels));
      write_reg(CSR_BITS, 32'(bits_per));
      write_reg(CSR_CODEC, 32'(codec));
      write_reg(CSR_PAYLOAD_BYTES, payload);
      // out-of-range index must leave every register alone
      write_reg(CSR_SPARE, $urandom);
      csr_we <= 1'b0;
   endtask

   // plen is the payload length, or the whole length for short and noise frames
   task automatic build_frame(input status_type fault, input int plen, input bit noise);
      logic [7:0]  hdr [HDR_LEN];
      logic [31:0] declared;
      int          k;
      frame_bytes.delete();
      if (noise || fault == ST_SHORT) begin
         repeat (plen) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
         return;
      end
      for (k = 0; k < HDR_LEN; k++) hdr[k] = 8'($urandom);
      hdr[0]  = MAGIC_0;
      hdr[1]  = MAGIC_1;
      hdr[2]  = MAGIC_2;
      hdr[3]  = MAGIC_3;
      hdr[4]  = cfg_version;
      hdr[5]  = cfg_kind;
      hdr[6]  = HDR_SIZE_VALUE[7:0];
      hdr[7]  = HDR_SIZE_VALUE[15:8];
      hdr[20] = cfg_channels;
      hdr[21] = cfg_bits;
      hdr[22] = cfg_codec;
      hdr[23] = 8'd0;
      for (k = 0; k < 4; k++) hdr[16 + k] = cfg_rate[8 * k +: 8];
      declared = 32'(plen);
      case (fault)
         ST_MAGIC:   hdr[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
         ST_VERSION: hdr[4] ^= 8'($urandom_range(1, 255));
         ST_HDRSIZE: hdr[6 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
         ST_KIND:    hdr[5] ^= 8'($urandom_range(1, 255));
         ST_LENGTH: begin
            // one off either way, or anything; zero minus one checks the wide compare
            case ($urandom_range(0, 2))
               0:       declared = declared + 1;
               1:       declared = declared - 1;
               default: declared = declared ^ $urandom_range(1, 32'hFFFF_FFFF);
            endcase
         end
         ST_FORMAT: begin
            case ($urandom_range(0, 4))
               0:       hdr[16 + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
               1:       hdr[20] ^= 8'($urandom_range(1, 255));
               2:       hdr[21] ^= 8'($urandom_range(1, 255));
               3:       hdr[22] ^= 8'($urandom_range(1, 255));
               default: hdr[23] = 8'($urandom_range(1, 255));
            endcase
         end
         default: ;
      endcase
      for (k = 0; k < 4; k++) hdr[24 + k] = declared[8 * k +: 8];
      for (k = 0; k < HDR_LEN; k++) frame_bytes.insert(frame_bytes.size(), hdr[k]);
      repeat (plen) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
   endtask

   // called at a rising edge; leaves req_tvalid high after the byte is taken
   task automatic send_byte(input logic [7:0] value, input logic is_last, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic run_frame(input status_type fault, input int plen, input bit noise);
      bit steady;
      int gap;
      int roll;
      int k;
      build_frame(fault, plen, noise);
      steady = ($urandom_range(0, 2) == 0);
      for (k = 0; k < frame_bytes.size(); k++) begin
         gap = 0;
         if (!steady) begin
            roll = $urandom_range(0, 99);
            if (roll >= 95) gap = $urandom_range(8, 30);
            else if (roll >= 70) gap = $urandom_range(1, 3);
         end
         send_byte(frame_bytes[k], k == frame_bytes.size() - 1, gap);
      end
      sent_bytes += frame_bytes.size();
   endtask

   initial begin
      int         goal;
      int         roll;
      int         plen;
      bit         noise;
      status_type fault;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset register values: short frames and a bare header
      run_frame(ST_SHORT, 1, 1'b0);
      run_frame(ST_SHORT, HDR_LEN - 1, 1'b0);
      run_frame(ST_SIZE, 0, 1'b0);

      // one payload byte, so the closing byte carries payload and summary
      load_registers(8'($urandom), 8'($urandom), $urandom, 8'($urandom), 8'($urandom),
                     8'($urandom), 32'd1);
      run_frame(ST_OK, 1, 1'b0);
      foreach (fault_menu[k]) run_frame(fault_menu[k], (fault_menu[k] == ST_SIZE) ? 0 : 1, 1'b0);

      load_registers(8'h00, 8'h00, 32'h0, 8'h00, 8'h00, 8'h00, 32'h0);
      run_frame(ST_OK, 0, 1'b0);
      run_frame(ST_LENGTH, 0, 1'b0);
      run_frame(ST_FORMAT, 0, 1'b0);

      load_registers(8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      run_frame(ST_SIZE, 2, 1'b0);
      run_frame(ST_VERSION, 0, 1'b0);
      run_frame(ST_KIND, 3, 1'b0);

      goal = sent_bytes + RANDOM_BYTE_GOAL;
      while (sent_bytes < goal) begin
         load_registers(8'($urandom), 8'($urandom), $urandom, 8'($urandom), 8'($urandom),
                        8'($urandom),
                        ($urandom_range(0, 9) == 0) ? $urandom
                                                    : $urandom_range(0, MAX_RANDOM_PAY));
         repeat ($urandom_range(3, 8)) begin
            roll  = $urandom_range(0, 19);
            noise = 1'b0;
            fault = ST_OK;
            plen  = $urandom_range(0, MAX_RANDOM_PAY);
            if (roll >= 16) begin
               noise = 1'b1;
               plen  = $urandom_range(1, 80);
            end else if (roll >= 8) begin
               fault = fault_menu[roll - 8];
            end
            if (fault == ST_OK && !noise) begin
               if (cfg_payload > MAX_RANDOM_PAY) fault = ST_SIZE;
               else plen = int'(cfg_payload);
            end
            if (fault == ST_SIZE && 32'(plen) == cfg_payload) plen++;
            if (fault == ST_SHORT) plen = $urandom_range(1, HDR_LEN - 1);
            run_frame(fault, plen, noise);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
